/* hw/rtl/arlq_pkg.sv */
// Shared types, constants and control structures of the adaptive range level quantizer.
// Used by arlq_alu, arlq_seq, arlq_dp and the top level; depends on nothing else.
package arlq_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIME_W      = 32;
    localparam int MARK_W      = 16;
    localparam int LEVEL_W     = 4;
    localparam int CNT_W       = 3;
    localparam int REFR_W      = 16;
    localparam int STEP_W      = $clog2(LEVEL_W);
    localparam int PROD_W      = MARK_W + LEVEL_W;
    localparam int ALU_W       = TIME_W + 1;

    localparam int IN_W        = SAMPLE_BITS + TIME_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = LEVEL_W + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 4;

    localparam logic signed [MARK_W-1:0] LOW_MARK_INIT  = 16'sd10000;
    localparam logic signed [MARK_W-1:0] HIGH_MARK_INIT = -16'sd10000;
    localparam logic signed [MARK_W:0]   MIN_SPAN       = 17'sd100;
    localparam logic [MARK_W-1:0]        PUSH_STEP      = 16'd50;
    localparam logic [CNT_W-1:0]         REPEAT_LIMIT   = 3'd6;
    localparam logic [LEVEL_W-1:0]       MAX_LEVELS     = 4'd10;
    localparam logic [LEVEL_W-1:0]       FALLBACK_LEVELS = 4'd3;
    localparam logic [LEVEL_W-1:0]       NUM_LEVELS_INIT = 4'd2;

    typedef enum logic [1:0] {
        REG_NUM_LEVELS = 2'd0,
        REG_REFRACTORY = 2'd1,
        REG_REST_LEVEL = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH,
        ST_SPAN,
        ST_PUSH,
        ST_REFR,
        ST_SPAN2,
        ST_OFS,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_HOLD
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOW,
        OP_HIGH,
        OP_SPAN,
        OP_PUSH,
        OP_REFR,
        OP_OFS,
        OP_MUL,
        OP_DIV,
        OP_FIN,
        OP_HOLD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
    } t_ctl;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               held_back;
        logic               recalibrated;
    } t_res;

endpackage

/* hw/rtl/arlq_alu.sv */
// Shared add/subtract unit of the quantizer datapath.
// Depends on arlq_pkg for the unit width.
module arlq_alu
    import arlq_pkg::*;
(
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ALU_W-1:0] o_sum
);

    logic [ALU_W-1:0] w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + w_b + {{(ALU_W-1){1'b0}}, i_sub};

endmodule

/* hw/rtl/arlq_seq.sv */
// Sequencer that steps one sample through the shared adder.
// Depends on arlq_pkg for the state, operation and control types.
module arlq_seq
    import arlq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_held,
    input  logic i_out_free,
    output logic o_ready,
    output t_ctl o_ctl
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_fire) n_state = ST_LOW;
            ST_LOW:   n_state = ST_HIGH;
            ST_HIGH:  n_state = ST_SPAN;
            ST_SPAN:  n_state = ST_PUSH;
            ST_PUSH:  n_state = ST_REFR;
            ST_REFR:  n_state = i_held ? ST_HOLD : ST_SPAN2;
            ST_SPAN2: n_state = ST_OFS;
            ST_OFS:   n_state = ST_MUL;
            ST_MUL:   if (r_step == {STEP_W{1'b1}}) n_state = ST_DIV;
            ST_DIV:   if (r_step == '0) n_state = ST_FIN;
            ST_FIN:   if (i_out_free) n_state = ST_IDLE;
            ST_HOLD:  if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // The multiply walks the level bits upward, the divide walks quotient bits downward.
    always_comb begin
        n_step = r_step;
        case (r_state)
            ST_OFS: n_step = '0;
            ST_MUL: begin
                if (r_step != {STEP_W{1'b1}}) n_step = r_step + 1'b1;
            end
            ST_DIV: n_step = r_step - 1'b1;
            default: n_step = r_step;
        endcase
    end

    always_comb begin
        o_ctl.step = r_step;
        o_ready    = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE:  o_ctl.op = i_in_fire ? OP_LOAD : OP_NONE;
            ST_LOW:   o_ctl.op = OP_LOW;
            ST_HIGH:  o_ctl.op = OP_HIGH;
            ST_SPAN:  o_ctl.op = OP_SPAN;
            ST_PUSH:  o_ctl.op = OP_PUSH;
            ST_REFR:  o_ctl.op = OP_REFR;
            ST_SPAN2: o_ctl.op = OP_SPAN;
            ST_OFS:   o_ctl.op = OP_OFS;
            ST_MUL:   o_ctl.op = OP_MUL;
            ST_DIV:   o_ctl.op = OP_DIV;
            ST_FIN:   o_ctl.op = i_out_free ? OP_FIN : OP_NONE;
            ST_HOLD:  o_ctl.op = i_out_free ? OP_HOLD : OP_NONE;
            default:  o_ctl.op = OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/arlq_dp.sv */
// Datapath of the quantizer: marks, counters and the serial multiply and divide.
// Depends on arlq_pkg and arlq_alu; driven by arlq_seq through t_ctl.
module arlq_dp
    import arlq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic [LEVEL_W-1:0]     i_num_levels,
    input  logic [REFR_W-1:0]      i_refractory_ms,
    input  logic [LEVEL_W-1:0]     i_rest_level,
    output logic                   o_held,
    output t_res                   o_res
);

    logic [SAMPLE_BITS-1:0]   r_s;
    logic [TIME_W-1:0]        r_now;
    logic signed [MARK_W:0]   r_span;
    logic [MARK_W-1:0]        r_ofs;
    logic [PROD_W-1:0]        r_prod;
    logic [LEVEL_W-1:0]       r_quo;
    logic signed [MARK_W-1:0] r_low;
    logic signed [MARK_W-1:0] r_high;
    logic [CNT_W-1:0]         r_cnt;
    logic [LEVEL_W-1:0]       r_held_lvl;
    logic [TIME_W-1:0]        r_last;

    logic signed [MARK_W:0]   n_span;
    logic [MARK_W-1:0]        n_ofs;
    logic [PROD_W-1:0]        n_prod;
    logic [LEVEL_W-1:0]       n_quo;
    logic signed [MARK_W-1:0] n_low;
    logic signed [MARK_W-1:0] n_high;
    logic [CNT_W-1:0]         n_cnt;
    logic [LEVEL_W-1:0]       n_held_lvl;
    logic [TIME_W-1:0]        n_last;

    logic [ALU_W-1:0]   w_a;
    logic [ALU_W-1:0]   w_b;
    logic               w_sub;
    logic [ALU_W-1:0]   w_sum;
    logic               w_neg;
    logic [ALU_W-1:0]   w_s_ext;
    logic [ALU_W-1:0]   w_low_ext;
    logic [ALU_W-1:0]   w_high_ext;
    logic [ALU_W-1:0]   w_ofs_ext;
    logic [ALU_W-1:0]   w_span_ext;
    logic [ALU_W-1:0]   w_prod_ext;
    logic [LEVEL_W-1:0] w_neff;
    logic [LEVEL_W-1:0] w_top;
    logic [LEVEL_W-1:0] w_x;
    logic               w_span_pos;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic               w_counts;
    logic               w_repeat;
    logic               w_recal;

    assign w_s_ext    = {{(ALU_W-SAMPLE_BITS){1'b0}}, r_s};
    assign w_low_ext  = {{(ALU_W-MARK_W){r_low[MARK_W-1]}}, r_low};
    assign w_high_ext = {{(ALU_W-MARK_W){r_high[MARK_W-1]}}, r_high};
    assign w_ofs_ext  = {{(ALU_W-MARK_W){1'b0}}, r_ofs};
    assign w_span_ext = {{(ALU_W-MARK_W){1'b0}}, r_span[MARK_W-1:0]};
    assign w_prod_ext = {{(ALU_W-PROD_W){1'b0}}, r_prod};

    arlq_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_sum (w_sum)
    );

    assign w_neg = w_sum[ALU_W-1];

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b1;
        case (i_ctl.op)
            OP_LOW: begin
                w_a = w_s_ext;
                w_b = w_low_ext;
            end
            OP_HIGH: begin
                w_a = w_high_ext;
                w_b = w_s_ext;
            end
            OP_SPAN: begin
                w_a = w_high_ext;
                w_b = w_low_ext;
            end
            OP_PUSH: begin
                // A rest level of zero opens the range downward, any other upward.
                w_a   = (i_rest_level == '0) ? w_low_ext : w_high_ext;
                w_b   = {{(ALU_W-MARK_W){1'b0}}, PUSH_STEP};
                w_sub = (i_rest_level == '0);
            end
            OP_REFR: begin
                w_a = {1'b0, r_now};
                w_b = {1'b0, r_last};
            end
            OP_OFS: begin
                w_a = w_s_ext;
                w_b = w_low_ext;
            end
            OP_MUL: begin
                w_a   = w_prod_ext;
                w_b   = w_neff[i_ctl.step] ? (w_ofs_ext << i_ctl.step) : '0;
                w_sub = 1'b0;
            end
            OP_DIV: begin
                w_a = w_prod_ext;
                w_b = w_span_ext << i_ctl.step;
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_sub = 1'b1;
            end
        endcase
    end

    assign o_held = (w_sum[TIME_W-1:0] < {{(TIME_W-REFR_W){1'b0}}, i_refractory_ms});

    always_comb begin
        if (i_num_levels > MAX_LEVELS) begin
            w_neff = FALLBACK_LEVELS;
        end else if (i_num_levels == '0) begin
            w_neff = LEVEL_W'(1);
        end else begin
            w_neff = i_num_levels;
        end
    end

    assign w_top      = w_neff - 1'b1;
    assign w_span_pos = !r_span[MARK_W] && (r_span != '0);
    assign w_x        = !w_span_pos ? '0 : ((r_quo > w_top) ? w_top : r_quo);
    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_counts   = (w_x != i_rest_level);
    assign w_repeat   = w_counts && (w_x == r_held_lvl);
    assign w_recal    = w_repeat && (w_cnt_inc > REPEAT_LIMIT);

    always_comb begin
        if (i_ctl.op == OP_HOLD) begin
            o_res.level        = r_held_lvl;
            o_res.held_back    = 1'b1;
            o_res.recalibrated = 1'b0;
        end else begin
            o_res.level        = w_x;
            o_res.held_back    = 1'b0;
            o_res.recalibrated = w_recal;
        end
    end

    always_comb begin
        n_span     = r_span;
        n_ofs      = r_ofs;
        n_prod     = r_prod;
        n_quo      = r_quo;
        n_low      = r_low;
        n_high     = r_high;
        n_cnt      = r_cnt;
        n_held_lvl = r_held_lvl;
        n_last     = r_last;
        case (i_ctl.op)
            OP_LOW:  if (w_neg) n_low = MARK_W'(r_s);
            OP_HIGH: if (w_neg) n_high = MARK_W'(r_s);
            OP_SPAN: n_span = w_sum[MARK_W:0];
            OP_PUSH: begin
                if (r_span < MIN_SPAN) begin
                    if (i_rest_level == '0) n_low = w_sum[MARK_W-1:0];
                    else                     n_high = w_sum[MARK_W-1:0];
                end
            end
            OP_OFS: begin
                n_ofs  = w_sum[MARK_W-1:0];
                n_prod = '0;
                n_quo  = '0;
            end
            OP_MUL: n_prod = w_sum[PROD_W-1:0];
            OP_DIV: begin
                if (!w_neg) begin
                    n_prod = w_sum[PROD_W-1:0];
                    n_quo[i_ctl.step] = 1'b1;
                end
            end
            OP_FIN: begin
                if (w_recal) begin
                    n_low      = LOW_MARK_INIT;
                    n_high     = HIGH_MARK_INIT;
                    n_cnt      = '0;
                    n_held_lvl = i_rest_level;
                    n_last     = r_now;
                end else if (w_repeat) begin
                    n_cnt = w_cnt_inc;
                end else if (w_counts) begin
                    n_held_lvl = w_x;
                    n_cnt      = '0;
                    n_last     = r_now;
                end
            end
            default: begin
                n_span = r_span;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low      <= LOW_MARK_INIT;
            r_high     <= HIGH_MARK_INIT;
            r_cnt      <= '0;
            r_held_lvl <= '0;
            r_last     <= '0;
        end else begin
            r_low      <= n_low;
            r_high     <= n_high;
            r_cnt      <= n_cnt;
            r_held_lvl <= n_held_lvl;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_LOAD) begin
            r_s   <= i_sample;
            r_now <= i_now_ms;
        end
        r_span <= n_span;
        r_ofs  <= n_ofs;
        r_prod <= n_prod;
        r_quo  <= n_quo;
    end

endmodule

/* hw/rtl/adaptive_range_level_quantizer_top.sv */
// A result is registered once its sample has passed the mark updates, a 4-step multiply and
// a 4-step divide on the shared adder; a level held by the refractory window skips the
// multiply and divide. A new sample is taken only after the last result has been registered.
// A finished result waits in the output register. Holds the APB registers and handshakes.
// Reset (synchronous, active low) restores the registers, marks, repeat count, held level
// and last event time to their initial values. Depends on arlq_pkg, arlq_seq and arlq_dp.
module adaptive_range_level_quantizer_top
    import arlq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample, now_ms, zero fill
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // level, held_back, recalibrated, zero fill
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [LEVEL_W-1:0]     r_num_levels;
    logic [REFR_W-1:0]      r_refractory_ms;
    logic [LEVEL_W-1:0]     r_rest_level;
    logic                   r_out_valid;
    t_res                   r_out;

    t_reg_idx               w_reg_idx;
    logic                   w_wr;
    logic                   w_in_fire;
    logic                   w_out_free;
    logic                   w_held;
    t_ctl                   w_ctl;
    t_res                   w_res;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels    <= NUM_LEVELS_INIT;
            r_refractory_ms <= '0;
            r_rest_level    <= '0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_NUM_LEVELS: r_num_levels    <= pwdata[LEVEL_W-1:0];
                REG_REFRACTORY: r_refractory_ms <= pwdata[REFR_W-1:0];
                REG_REST_LEVEL: r_rest_level    <= pwdata[LEVEL_W-1:0];
                default:        r_rest_level    <= r_rest_level;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_NUM_LEVELS: prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, r_num_levels};
            REG_REFRACTORY: prdata = {{(APB_DATA_W-REFR_W){1'b0}}, r_refractory_ms};
            REG_REST_LEVEL: prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, r_rest_level};
            default:        prdata = '0;
        endcase
    end

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    arlq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_held     (w_held),
        .i_out_free (w_out_free),
        .o_ready    (s_axis_tready),
        .o_ctl      (w_ctl)
    );

    arlq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_sample        (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_now_ms        (s_axis_tdata[IN_W-1:SAMPLE_BITS]),
        .i_num_levels    (r_num_levels),
        .i_refractory_ms (r_refractory_ms),
        .i_rest_level    (r_rest_level),
        .o_held          (w_held),
        .o_res           (w_res)
    );

    // The result register is loaded only when it is empty or being drained this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.op == OP_FIN || w_ctl.op == OP_HOLD) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == OP_FIN || w_ctl.op == OP_HOLD) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}},
                            r_out.recalibrated, r_out.held_back, r_out.level};

endmodule
